[rtl/msa_pkg.sv]
// Shared types and constants for the multi-stack shared array core.
package msa_pkg;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Width of the stack number field on the input word.
  localparam int unsigned StackNumWidth = 3;
  // Width used to compare a stack number against the stack count.
  localparam int unsigned StackCmpWidth = 7;
  localparam int unsigned ItemWidth     = 32;

endpackage

[rtl/msa_if.sv]
// Handshake interfaces for the command and result channels.
interface msa_in_if
  import msa_pkg::*;
();
  logic                               valid;
  logic                               ready;
  op_e                                operation;
  logic [StackNumWidth-1:0]           stack_number;
  logic signed [ItemWidth-1:0]        item;

  modport source (output valid, output operation, output stack_number, output item,
                  input ready);
  modport sink   (input valid, input operation, input stack_number, input item,
                  output ready);
endinterface

interface msa_out_if
  import msa_pkg::*;
();
  logic                               valid;
  logic                               ready;
  status_e                            status;
  logic signed [ItemWidth-1:0]        data;
  logic                               last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

[rtl/msa_entry_store.sv]
// Entry memory shared by all stacks: one write port, one registered read port.
module msa_entry_store
  import msa_pkg::*;
#(
  parameter int unsigned Entries   = 512,
  parameter int unsigned AddrWidth = 9,
  parameter int unsigned DataWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AddrWidth-1:0]        wr_addr_i,
  input  logic signed [DataWidth-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AddrWidth-1:0]        rd_addr_i,
  output logic signed [DataWidth-1:0] rd_data_o
);

  logic signed [DataWidth-1:0] mem [Entries];
  logic signed [DataWidth-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // The read word holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/msa_fill_store.sv]
// Fill count memory, one count per stack, with per-stack valid bits cleared by reset.
module msa_fill_store
  import msa_pkg::*;
#(
  parameter int unsigned NumStacks  = 8,
  parameter int unsigned IdxWidth   = 3,
  parameter int unsigned CountWidth = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IdxWidth-1:0]   wr_idx_i,
  input  logic [CountWidth-1:0] wr_count_i,
  input  logic                  rd_en_i,
  input  logic [IdxWidth-1:0]   rd_idx_i,
  output logic [CountWidth-1:0] rd_count_o
);

  logic [CountWidth-1:0] mem [NumStacks];
  logic [NumStacks-1:0]  vld_q;
  logic [CountWidth-1:0] rd_raw_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_count_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  // A stack never written since reset reads as empty.
  assign rd_count_o = rd_vld_q ? rd_raw_q : '0;

endmodule

[rtl/multi_stack_shared_array_core.sv]
// Multi-stack core: push, pop and display on stacks that share one entry memory.
// Sequence: push, no-op and every error load their word once the fill count is read;
// pop and display first read the top entry, and display then reads one entry per word
// down to the bottom. A new command is taken only after the last word of the previous
// one is loaded, and a stalled output holds the sequencer.
// Reset: every stack is empty at once through the fill count valid bits; the entry
// memory is not cleared and needs no clearing pass.
module multi_stack_shared_array_core
  import msa_pkg::*;
#(
  parameter int unsigned NUM_STACKS  = 8,
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msa_in_if.sink    in_i,
  msa_out_if.source out_o
);

  // Derived widths. Stack s owns entries s*STACK_DEPTH to s*STACK_DEPTH+STACK_DEPTH-1.
  localparam int unsigned Entries  = NUM_STACKS * STACK_DEPTH;
  localparam int unsigned IdxW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned PosW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned SnExtW   = (IdxW > StackNumWidth) ? IdxW : StackNumWidth;

  // Sequencer states. In S_FILL the stack's fill count is on hand; in S_READ an
  // entry word is on hand.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  // Latched command.
  op_e                          op_q;
  logic [IdxW-1:0]              idx_q;
  logic                         in_range_q;
  logic signed [DATA_WIDTH-1:0] item_q;

  // Position of the entry being read, counting down during a display.
  logic [PosW-1:0] pos_q, pos_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  status_e                     out_status_q, out_status_d;
  logic signed [ItemWidth-1:0] out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;
  logic                        out_load;
  logic                        out_free;

  // Memory ports.
  logic                         fill_rd_en;
  logic [CntW-1:0]              fill;
  logic                         fill_wr_en;
  logic [CntW-1:0]              fill_wr_count;
  logic                         ent_wr_en;
  logic                         ent_rd_en;
  logic [PosW-1:0]              ent_pos;
  logic [AddrW-1:0]             ent_addr;
  logic signed [DATA_WIDTH-1:0] ent_rd_data;

  logic                in_accept;
  logic [SnExtW-1:0]   sn_ext;
  logic [IdxW-1:0]     in_idx;
  logic                in_range;
  logic                full;
  logic                empty;
  logic [PosW-1:0]     top_pos;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // The stack number is widened before slicing so that any stack count fits.
  assign sn_ext   = SnExtW'(in_i.stack_number);
  assign in_idx   = sn_ext[IdxW-1:0];
  assign in_range = StackCmpWidth'(in_i.stack_number) < StackCmpWidth'(NUM_STACKS);

  assign fill_rd_en = in_accept;

  assign full    = (fill == CntW'(STACK_DEPTH));
  assign empty   = (fill == '0);
  assign top_pos = PosW'(fill - CntW'(1));

  // An output word may be loaded when the register is empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= in_i.operation;
      idx_q      <= in_idx;
      in_range_q <= in_range;
      // Wider storage keeps the sign of the item; narrower storage keeps its low bits.
      item_q     <= DATA_WIDTH'(in_i.item);
    end
  end

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    out_load      = 1'b0;
    out_status_d  = ST_OK;
    out_data_d    = '0;
    out_last_d    = 1'b1;
    fill_wr_en    = 1'b0;
    fill_wr_count = fill;
    ent_wr_en     = 1'b0;
    ent_rd_en     = 1'b0;
    ent_pos       = top_pos;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        if (op_q == OP_NOP) begin
          out_load = out_free;
        end else if (!in_range_q) begin
          out_status_d = ST_EMPTY;
          out_load     = out_free;
        end else if (op_q == OP_PUSH) begin
          // The new item goes to the slot just above the current top.
          ent_pos = PosW'(fill);
          if (full) begin
            out_status_d = ST_OVERFLOW;
            out_load     = out_free;
          end else begin
            out_load      = out_free;
            ent_wr_en     = out_free;
            fill_wr_en    = out_free;
            fill_wr_count = fill + CntW'(1);
          end
        end else if (empty) begin
          // Pop of an empty stack and display of an empty stack report alike.
          out_status_d = ST_EMPTY;
          out_load     = out_free;
        end else begin
          // Pop and display both start by reading the top entry.
          ent_rd_en = 1'b1;
          pos_d     = top_pos;
          state_d   = S_READ;
          if (op_q == OP_POP) begin
            fill_wr_en    = 1'b1;
            fill_wr_count = fill - CntW'(1);
          end
        end
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      S_READ: begin
        ent_pos    = pos_q - PosW'(1);
        out_data_d = ItemWidth'(ent_rd_data);
        out_last_d = (op_q == OP_POP) || (pos_q == '0);
        if (out_free) begin
          out_load = 1'b1;
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            // Walk down one entry towards the bottom of the stack.
            ent_rd_en = 1'b1;
            pos_d     = pos_q - PosW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ent_addr = AddrW'(idx_q) * AddrW'(STACK_DEPTH) + AddrW'(ent_pos);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.data   = out_data_q;
  assign out_o.last   = out_last_q;

  msa_fill_store #(
    .NumStacks (NUM_STACKS),
    .IdxWidth  (IdxW),
    .CountWidth(CntW)
  ) u_fill_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fill_wr_en),
    .wr_idx_i  (idx_q),
    .wr_count_i(fill_wr_count),
    .rd_en_i   (fill_rd_en),
    .rd_idx_i  (in_idx),
    .rd_count_o(fill)
  );

  msa_entry_store #(
    .Entries  (Entries),
    .AddrWidth(AddrW),
    .DataWidth(DATA_WIDTH)
  ) u_entry_store (
    .clk_i    (clk_i),
    .wr_en_i  (ent_wr_en),
    .wr_addr_i(ent_addr),
    .wr_data_i(item_q),
    .rd_en_i  (ent_rd_en),
    .rd_addr_i(ent_addr),
    .rd_data_o(ent_rd_data)
  );

endmodule

[dv/multi_stack_shared_array_core_tb.sv]
// Testbench for the multi-stack core: mirrors every stack and checks each result word.
module multi_stack_shared_array_core_tb;
  import msa_pkg::*;

  localparam int unsigned NumStacks  = 8;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned ItemCount  = 480;
  // Percentage of cycles in which each side holds back.
  localparam int unsigned IdlePct    = 11;
  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned QuietLimit = 1000;
  // Tail wait, sized from the stack depth to cover a display of a full stack.
  localparam int unsigned TailCycles = StackDepth + 10;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    status_e              status;
    logic [ItemWidth-1:0] data;
    logic                 last;
  } result_word_t;

  // Keeps its own copy of every stack and the queue of result words still owed
  // by the core. Commands are noted as they are accepted, and each result word
  // is compared with the oldest word owed.
  class stack_mirror;
    logic [ItemWidth-1:0] entries [NumStacks*StackDepth];
    int unsigned          fill [NumStacks];
    result_word_t         owed [$];
    int unsigned          faults;

    function new();
      foreach (fill[s]) fill[s] = 0;
      faults = 0;
    endfunction

    function void owe(status_e st, logic [ItemWidth-1:0] d, logic l);
      result_word_t w;
      w.status = st;
      w.data   = d;
      w.last   = l;
      owed.push_back(w);
    endfunction

    function void note_command(op_e op, logic [StackNumWidth-1:0] sn,
                               logic [ItemWidth-1:0] val);
      int unsigned base;
      int unsigned n;
      if (op == OP_NOP) begin
        owe(ST_OK, '0, 1'b1);
        return;
      end
      if (sn >= NumStacks) begin
        owe(ST_EMPTY, '0, 1'b1);
        return;
      end
      base = sn * StackDepth;
      n    = fill[sn];
      case (op)
        OP_PUSH: begin
          if (n >= StackDepth) begin
            owe(ST_OVERFLOW, '0, 1'b1);
          end else begin
            entries[base + n] = val;
            fill[sn] = n + 1;
            owe(ST_OK, '0, 1'b1);
          end
        end
        OP_POP: begin
          if (n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            fill[sn] = n - 1;
            owe(ST_OK, entries[base + n - 1], 1'b1);
          end
        end
        default: begin
          // Display walks from the top entry down to the bottom one.
          if (n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int j = int'(n) - 1; j >= 0; j--) owe(ST_OK, entries[base + j], j == 0);
          end
        end
      endcase
    endfunction

    function void check_word(status_e st, logic [ItemWidth-1:0] d, logic l);
      result_word_t w;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= ReportMax)
          $display("word with nothing owed: status %0d data %h last %b", st, d, l);
        return;
      end
      w = owed.pop_front();
      if (w.status !== st || w.data !== d || w.last !== l) begin
        faults++;
        if (faults <= ReportMax)
          $display("word mismatch: expected status %0d data %h last %b, got %0d %h %b",
                   w.status, w.data, w.last, st, d, l);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  // While set, neither side holds back, so the core runs at its full rate.
  logic        calm = 1'b0;
  int unsigned quiet_cycles = 0;

  msa_in_if  cmd_if ();
  msa_out_if word_if ();

  stack_mirror mirror = new();

  multi_stack_shared_array_core #(
    .NUM_STACKS (NumStacks),
    .STACK_DEPTH(StackDepth),
    .DATA_WIDTH (ItemWidth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (word_if)
  );

  always #10 clk_i = ~clk_i;

  // The receiving side stalls at random, except in the calm stretch.
  always @(posedge clk_i) begin
    word_if.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Both channels are sampled at the clock edge, so the values seen are those
  // that held during the cycle just ended. The result word is checked before
  // the command is noted; a command cannot produce a word at its own edge.
  // The same block keeps the watchdog, which counts cycles with no handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (word_if.valid && word_if.ready)
        mirror.check_word(word_if.status, word_if.data, word_if.last);
      if (cmd_if.valid && cmd_if.ready)
        mirror.note_command(cmd_if.operation, cmd_if.stack_number, cmd_if.item);
      if ((cmd_if.valid && cmd_if.ready) || (word_if.valid && word_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one command and returns at the edge where it is accepted. The
  // valid is only lowered when an idle cycle is actually inserted, so a
  // command that follows straight on keeps valid high without a glitch.
  task automatic send_command(op_e op, logic [StackNumWidth-1:0] sn,
                              logic [ItemWidth-1:0] val);
    while (!calm && $urandom_range(99) < IdlePct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.operation    <= op;
    cmd_if.stack_number <= sn;
    cmd_if.item         <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // Mostly random words, with the extremes of the signed range now and then.
  function automatic logic [ItemWidth-1:0] pick_item();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic op_e pick_op(int unsigned push_pct, int unsigned pop_pct,
                                  int unsigned show_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return OP_PUSH;
    if (r < push_pct + pop_pct) return OP_POP;
    if (r < push_pct + pop_pct + show_pct) return OP_DISPLAY;
    return OP_NOP;
  endfunction

  // One phase of random traffic. The share of commands set by focus_pct goes to the
  // target stack, so a push-heavy phase fills it past its depth and a pop-heavy one drains it
  // past empty; the rest are spread over all stacks.
  task automatic run_phase(int unsigned len, int unsigned target, int unsigned push_pct,
                           int unsigned pop_pct, int unsigned show_pct,
                           int unsigned focus_pct, inout int unsigned sent);
    logic [StackNumWidth-1:0] sn;
    for (int unsigned k = 0; k < len && sent < ItemCount; k++) begin
      sn = StackNumWidth'(($urandom_range(99) < focus_pct) ? target
                                                            : $urandom_range(NumStacks - 1));
      calm <= (sent >= 250 && sent < 330);
      send_command(pick_op(push_pct, pop_pct, show_pct), sn, pick_item());
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned target;
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.operation    = OP_NOP;
    cmd_if.stack_number = '0;
    cmd_if.item         = '0;
    word_if.ready       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty display and pop underflow, the extremes of the
    // item pushed and read back both by display and by pop, a no-op, and
    // alternating bit patterns on the top stack number.
    send_command(OP_DISPLAY, 0, '0);
    send_command(OP_POP,     0, '1);
    send_command(OP_PUSH,    0, 32'h7FFF_FFFF);
    send_command(OP_PUSH,    0, 32'h8000_0000);
    send_command(OP_PUSH,    0, '0);
    send_command(OP_PUSH,    0, '1);
    send_command(OP_DISPLAY, 0, '0);
    send_command(OP_POP,     0, '0);
    send_command(OP_NOP,     5, 32'h1234_5678);
    send_command(OP_PUSH,    7, 32'h5555_5555);
    send_command(OP_PUSH,    7, 32'hAAAA_AAAA);
    send_command(OP_DISPLAY, 7, '0);
    send_command(OP_POP,     7, '0);
    send_command(OP_POP,     7, '0);
    send_command(OP_POP,     7, '0);
    send_command(OP_PUSH,    3, 32'd1);
    send_command(OP_DISPLAY, 3, '0);
    send_command(OP_POP,     0, '0);
    send_command(OP_POP,     0, '0);
    send_command(OP_POP,     0, '0);
    send_command(OP_POP,     0, '0);

    // Random part: rounds of fill and drain on a random stack, then mixed traffic on all stacks.
    sent = 0;
    while (sent < ItemCount) begin
      target = $urandom_range(NumStacks - 1);
      run_phase(100, target, 90, 4, 4, 90, sent);
      run_phase(110, target, 8, 80, 10, 90, sent);
      run_phase(40, target, 30, 30, 25, 0, sent);
    end
    cmd_if.valid <= 1'b0;
    calm         <= 1'b0;

    // Wait for every owed word, then long enough for a stray extra one to show.
    while (mirror.owed.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mirror.faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
